[design/crp_pkg.sv]
`default_nettype none

package crp_pkg;

  // Operation codes carried in the operation field of a request.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_BELOW  = 2'd1,
    ST_ABOVE  = 2'd2,
    ST_WRITE  = 2'd3
  } ramp_status_t;

  // Colors returned outside the ramp.
  localparam logic [7:0] BELOW_RED   = 8'd150;
  localparam logic [7:0] BELOW_GREEN = 8'd150;
  localparam logic [7:0] BELOW_BLUE  = 8'd255;
  localparam logic [7:0] ABOVE_LEVEL = 8'd255;

  // Depth of the request queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Width of the quotient produced by the serial divider.
  localparam int QUOT_W = 8;

  // Input request payload.
  typedef struct packed {
    logic               operation;
    logic [3:0]         point_slot;
    logic signed [15:0] point_height;
    logic [7:0]         point_red;
    logic [7:0]         point_green;
    logic [7:0]         point_blue;
    logic signed [15:0] query_height;
  } crp_in_t;

  // Result payload.
  typedef struct packed {
    logic [7:0]   out_red;
    logic [7:0]   out_green;
    logic [7:0]   out_blue;
    ramp_status_t ramp_status;
  } crp_out_t;

  // One stored ramp point.
  typedef struct packed {
    logic signed [15:0] height;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } ramp_point_t;

  // A classified request as it sits in the queue.
  typedef struct packed {
    logic               is_lookup;
    logic               slot_ok;
    logic [3:0]         slot;
    ramp_point_t        point;
    logic signed [15:0] query;
  } crp_entry_t;

  // Queue status seen by the front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } crp_qstat_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DECIDE,
    BK_MUL,
    BK_DIV,
    BK_ACC,
    BK_FIN
  } back_state_t;

endpackage

`default_nettype wire

[design/crp_front.sv]
`default_nettype none

module crp_front #(
  parameter int MAX_POINTS = 16,
  parameter int SC_W       = 5
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  crp_pkg::crp_in_t     in_data,
  input  wire                  cfg_wr_en,
  input  wire [4:0]            cfg_wr_data,
  input  crp_pkg::crp_qstat_t  qstat,
  output logic                 push,
  output crp_pkg::crp_entry_t  entry,
  output logic [SC_W-1:0]      scan_lim
);

  logic [SC_W-1:0] scan_lim_r;
  logic [SC_W-1:0] scan_lim_nxt;

  // The point count is clamped to the table depth when it is written.
  always_comb begin
    if ({27'b0, cfg_wr_data} > 32'(MAX_POINTS)) begin
      scan_lim_nxt = SC_W'(MAX_POINTS);
    end else begin
      scan_lim_nxt = SC_W'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_lim_r <= '0;
    end else if (cfg_wr_en) begin
      scan_lim_r <= scan_lim_nxt;
    end
  end

  assign scan_lim = scan_lim_r;

  // A request is taken whenever the queue has room.
  assign in_stall = qstat.full;
  assign push     = in_valid && !qstat.full;

  // Classify the request and flag writes to slots past the table.
  always_comb begin
    entry.is_lookup    = (in_data.operation == crp_pkg::OP_LOOKUP);
    entry.slot_ok      = ({28'b0, in_data.point_slot} < 32'(MAX_POINTS));
    entry.slot         = in_data.point_slot;
    entry.point.height = in_data.point_height;
    entry.point.red    = in_data.point_red;
    entry.point.green  = in_data.point_green;
    entry.point.blue   = in_data.point_blue;
    entry.query        = in_data.query_height;
  end

endmodule

`default_nettype wire

[design/crp_queue.sv]
`default_nettype none

module crp_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  crp_pkg::crp_entry_t  push_entry,
  input  wire                  pop,
  output crp_pkg::crp_entry_t  head,
  output crp_pkg::crp_qstat_t  qstat
);

  crp_pkg::crp_entry_t              slots_r [crp_pkg::QUEUE_DEPTH];
  logic [crp_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [crp_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [crp_pkg::QCNT_W-1:0]       count_r;
  logic                             do_push;
  logic                             do_pop;

  assign qstat.full  = (count_r == crp_pkg::QCNT_W'(crp_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = slots_r[rd_ptr_r];

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

[design/crp_back.sv]
`default_nettype none

module crp_back #(
  parameter int MAX_POINTS = 16,
  parameter int SC_W       = 5,
  parameter int IDX_W      = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  crp_pkg::crp_entry_t  head,
  input  crp_pkg::crp_qstat_t  qstat,
  output logic                 pop,
  input  wire [SC_W-1:0]       scan_lim,
  output logic                 out_valid,
  input  wire                  out_stall,
  output crp_pkg::crp_out_t    out_data
);

  crp_pkg::back_state_t   state_r;
  crp_pkg::back_state_t   state_nxt;

  crp_pkg::ramp_point_t   table_mem [MAX_POINTS];
  crp_pkg::ramp_point_t   rd_point_r;
  logic                   rd_vld_r;
  logic [SC_W-1:0]        iss_r;

  logic signed [15:0]     query_r;
  logic                   has_lo_r;
  logic                   has_hi_r;
  crp_pkg::ramp_point_t   lo_r;
  crp_pkg::ramp_point_t   hi_r;

  logic [15:0]            num_r;
  logic [15:0]            den_r;
  logic [1:0]             ch_r;
  logic [2:0]             step_r;
  logic [23:0]            prod_r;
  logic [23:0]            dsh_r;
  logic                   neg_r;
  logic [crp_pkg::QUOT_W-1:0] quot_r;
  logic [2:0][7:0]        res_r;
  crp_pkg::ramp_status_t  st_r;

  logic                   out_valid_r;
  crp_pkg::crp_out_t      out_data_r;
  logic                   out_free;

  logic                   load_wr;
  logic                   mem_we;
  logic                   start_scan;
  logic                   scan_issue;
  logic                   scan_done;
  logic                   fin_load;
  logic                   special;

  logic                   take_lo;
  logic                   take_hi;
  logic [7:0]             cl;
  logic [7:0]             cu;
  logic [8:0]             diff9;
  logic [8:0]             neg9;
  logic [7:0]             mag;
  logic [16:0]            num17;
  logic [16:0]            den17;

  assign out_free = !out_valid_r || !out_stall;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      crp_pkg::BK_IDLE: begin
        if (start_scan) begin
          state_nxt = crp_pkg::BK_SCAN;
        end
      end
      crp_pkg::BK_SCAN: begin
        if (scan_done) begin
          state_nxt = crp_pkg::BK_DECIDE;
        end
      end
      crp_pkg::BK_DECIDE: begin
        state_nxt = special ? crp_pkg::BK_FIN : crp_pkg::BK_MUL;
      end
      crp_pkg::BK_MUL: begin
        state_nxt = crp_pkg::BK_DIV;
      end
      crp_pkg::BK_DIV: begin
        if (step_r == 3'd7) begin
          state_nxt = crp_pkg::BK_ACC;
        end
      end
      crp_pkg::BK_ACC: begin
        state_nxt = (ch_r == 2'd2) ? crp_pkg::BK_FIN : crp_pkg::BK_MUL;
      end
      crp_pkg::BK_FIN: begin
        if (out_free) begin
          state_nxt = crp_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = crp_pkg::BK_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    pop        = 1'b0;
    load_wr    = 1'b0;
    mem_we     = 1'b0;
    start_scan = 1'b0;
    scan_issue = 1'b0;
    scan_done  = 1'b0;
    fin_load   = 1'b0;
    unique case (state_r)
      crp_pkg::BK_IDLE: begin
        if (!qstat.empty) begin
          if (head.is_lookup) begin
            pop        = 1'b1;
            start_scan = 1'b1;
          end else if (out_free) begin
            pop     = 1'b1;
            load_wr = 1'b1;
            mem_we  = head.slot_ok;
          end
        end
      end
      crp_pkg::BK_SCAN: begin
        scan_issue = (iss_r < scan_lim);
        scan_done  = (iss_r >= scan_lim) && !rd_vld_r;
      end
      crp_pkg::BK_FIN: begin
        fin_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crp_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Point table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[IDX_W'(head.slot)] <= head.point;
    end
    rd_point_r <= table_mem[iss_r[IDX_W-1:0]];
  end

  // Scan address counter and read-data valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (start_scan) begin
      iss_r <= '0;
    end else if (scan_issue) begin
      iss_r <= iss_r + 1'b1;
    end
  end

  // Bracket tests; a strict compare keeps the first of equal heights.
  assign take_lo = rd_vld_r && (rd_point_r.height <= query_r)
                   && (!has_lo_r || (rd_point_r.height > lo_r.height));
  assign take_hi = rd_vld_r && (rd_point_r.height >= query_r)
                   && (!has_hi_r || (rd_point_r.height < hi_r.height));

  always_ff @(posedge clk) begin
    if (start_scan) begin
      query_r  <= head.query;
      has_lo_r <= 1'b0;
      has_hi_r <= 1'b0;
    end else begin
      if (take_lo) begin
        has_lo_r <= 1'b1;
        lo_r     <= rd_point_r;
      end
      if (take_hi) begin
        has_hi_r <= 1'b1;
        hi_r     <= rd_point_r;
      end
    end
  end

  // Offsets for the blend; both are non-negative when interpolating.
  assign num17   = {query_r[15], query_r} - {lo_r.height[15], lo_r.height};
  assign den17   = {hi_r.height[15], hi_r.height} - {lo_r.height[15], lo_r.height};
  assign special = !has_lo_r || !has_hi_r || (lo_r.height == hi_r.height);

  // Channel selection for the shared multiply-divide unit.
  always_comb begin
    unique case (ch_r)
      2'd0: begin
        cl = lo_r.red;
        cu = hi_r.red;
      end
      2'd1: begin
        cl = lo_r.green;
        cu = hi_r.green;
      end
      default: begin
        cl = lo_r.blue;
        cu = hi_r.blue;
      end
    endcase
  end

  assign diff9 = {1'b0, cu} - {1'b0, cl};
  assign neg9  = 9'd0 - diff9;
  assign mag   = diff9[8] ? neg9[7:0] : diff9[7:0];

  // Blend datapath: magnitude product, restoring division, signed correction.
  always_ff @(posedge clk) begin
    unique case (state_r)
      crp_pkg::BK_DECIDE: begin
        num_r <= num17[15:0];
        den_r <= den17[15:0];
        ch_r  <= 2'd0;
        if (!has_lo_r) begin
          st_r  <= crp_pkg::ST_BELOW;
          res_r <= {crp_pkg::BELOW_BLUE, crp_pkg::BELOW_GREEN, crp_pkg::BELOW_RED};
        end else if (!has_hi_r) begin
          st_r  <= crp_pkg::ST_ABOVE;
          res_r <= {crp_pkg::ABOVE_LEVEL, crp_pkg::ABOVE_LEVEL, crp_pkg::ABOVE_LEVEL};
        end else begin
          st_r  <= crp_pkg::ST_INTERP;
          res_r <= {lo_r.blue, lo_r.green, lo_r.red};
        end
      end
      crp_pkg::BK_MUL: begin
        prod_r <= 24'(mag) * 24'(num_r);
        dsh_r  <= {1'b0, den_r, 7'b0};
        neg_r  <= diff9[8];
        quot_r <= '0;
        step_r <= 3'd0;
      end
      crp_pkg::BK_DIV: begin
        if (prod_r >= dsh_r) begin
          prod_r <= prod_r - dsh_r;
          quot_r <= {quot_r[crp_pkg::QUOT_W-2:0], 1'b1};
        end else begin
          quot_r <= {quot_r[crp_pkg::QUOT_W-2:0], 1'b0};
        end
        dsh_r  <= dsh_r >> 1;
        step_r <= step_r + 3'd1;
      end
      crp_pkg::BK_ACC: begin
        res_r[ch_r] <= neg_r ? (cl - quot_r) : (cl + quot_r);
        ch_r        <= ch_r + 2'd1;
      end
      default: begin
      end
    endcase
  end

  // Result register decouples the sequencer from the output stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_wr || fin_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_wr) begin
      out_data_r.out_red     <= 8'd0;
      out_data_r.out_green   <= 8'd0;
      out_data_r.out_blue    <= 8'd0;
      out_data_r.ramp_status <= crp_pkg::ST_WRITE;
    end else if (fin_load) begin
      out_data_r.out_red     <= res_r[0];
      out_data_r.out_green   <= res_r[1];
      out_data_r.out_blue    <= res_r[2];
      out_data_r.ramp_status <= st_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[design/color_ramp_interpolation.sv]
`default_nettype none

// Elevation to color ramp. A write request stores a point (height and RGB) in
// the table slot it names and returns a write-done result; a lookup scans the
// first points_in_use entries (clamped to MAX_POINTS), brackets the query
// height and returns the exact or linearly blended color, or a fixed color
// below or above the ramp. Requests enter a two-entry queue and are executed
// one at a time. With the back end idle and the result register free, a write
// is popped from the queue head and its result is registered. In a lookup the
// scan reads one entry per cycle through the table's single read port, and
// the blend runs the three channels in turn through one multiplier and an
// 8-step restoring divider. A lookup below or above the ramp, or exactly on a
// point, skips the blend. A stalled result holds the back end, and the queue
// then fills and stalls the input. Entries must be written before a lookup
// scans them; the table is not cleared by reset.
module color_ramp_interpolation #(
  parameter int MAX_POINTS = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  crp_pkg::crp_in_t  in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output crp_pkg::crp_out_t out_data,
  input  wire               cfg_wr_en,
  input  wire [4:0]         cfg_wr_data
);

  localparam int SC_W  = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = $clog2(MAX_POINTS);

  crp_pkg::crp_qstat_t qstat;
  crp_pkg::crp_entry_t push_entry;
  crp_pkg::crp_entry_t head;
  logic                push;
  logic                pop;
  logic [SC_W-1:0]     scan_lim;

  crp_front #(
    .MAX_POINTS (MAX_POINTS),
    .SC_W       (SC_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .qstat       (qstat),
    .push        (push),
    .entry       (push_entry),
    .scan_lim    (scan_lim)
  );

  crp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  crp_back #(
    .MAX_POINTS (MAX_POINTS),
    .SC_W       (SC_W),
    .IDX_W      (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .scan_lim  (scan_lim),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[design/crp_checker.sv]
`default_nettype none

module crp_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               out_valid,
  input wire               out_stall,
  input crp_pkg::crp_out_t out_data
);

  // A stalled result stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // Write acknowledgments carry a black color.
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.ramp_status == crp_pkg::ST_WRITE) |->
      (out_data.out_red == 8'd0) && (out_data.out_green == 8'd0) &&
      (out_data.out_blue == 8'd0))
    else $error("write result has nonzero color");

  // Below the ramp the fixed water color is returned.
  a_below: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.ramp_status == crp_pkg::ST_BELOW) |->
      (out_data.out_red == crp_pkg::BELOW_RED) &&
      (out_data.out_green == crp_pkg::BELOW_GREEN) &&
      (out_data.out_blue == crp_pkg::BELOW_BLUE))
    else $error("below-ramp color wrong");

  // Above the ramp the result is white.
  a_above: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.ramp_status == crp_pkg::ST_ABOVE) |->
      (out_data.out_red == crp_pkg::ABOVE_LEVEL) &&
      (out_data.out_green == crp_pkg::ABOVE_LEVEL) &&
      (out_data.out_blue == crp_pkg::ABOVE_LEVEL))
    else $error("above-ramp color wrong");

endmodule

bind color_ramp_interpolation crp_checker u_crp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

[dv/tb_color_ramp_interpolation.sv]
`timescale 1ns / 100ps

module tb_color_ramp_interpolation;
  import crp_pkg::*;

  localparam int TABLE_SIZE    = 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 60;
  localparam int SHOWN_LIMIT   = 10;

  // How widely random ramp heights are spread.
  typedef enum int {
    SPREAD_FULL,
    SPREAD_NARROW,
    SPREAD_MEDIUM
  } spread_t;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  crp_in_t    in_data     = '0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  crp_out_t   out_data;
  logic       cfg_wr_en   = 1'b0;
  logic [4:0] cfg_wr_data = '0;

  bit       idle_on     = 1'b0;
  int       stall_left  = 0;
  int       err_count   = 0;
  int       shown_count = 0;
  crp_out_t expected_color;

  // Testbench copy of the ramp table and of the scan length register.
  ramp_point_t ramp_tbl [TABLE_SIZE];
  int          ramp_length = 0;
  crp_out_t    pending_colors [$];

  color_ramp_interpolation #(
    .MAX_POINTS(TABLE_SIZE)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("tb_color_ramp_interpolation: errors");
    $finish;
  end

  // One color channel between two points, truncated toward zero.
  function automatic logic [7:0] blend_channel(logic [7:0] c_lo, logic [7:0] c_hi,
                                               int num, int den);
    int delta;
    delta = (int'(c_hi) - int'(c_lo)) * num;
    return 8'(int'(c_lo) + delta / den);
  endfunction

  // Expected result of one request; a write also updates the table copy.
  function automatic crp_out_t ramp_color(crp_in_t req);
    crp_out_t res;
    int       span, q, h, lo, hi, num, den;
    bit       has_lo, has_hi;
    res = '0;
    if (req.operation == OP_WRITE) begin
      ramp_tbl[req.point_slot] = '{req.point_height, req.point_red,
                                   req.point_green, req.point_blue};
      res.ramp_status = ST_WRITE;
      return res;
    end
    span   = (ramp_length < TABLE_SIZE) ? ramp_length : TABLE_SIZE;
    q      = $signed(req.query_height);
    has_lo = 1'b0;
    has_hi = 1'b0;
    lo     = 0;
    hi     = 0;
    // The first entry wins among equal heights, hence the strict compares.
    for (int i = 0; i < span; i++) begin
      h = $signed(ramp_tbl[i].height);
      if (h <= q && (!has_lo || h > $signed(ramp_tbl[lo].height))) begin
        lo     = i;
        has_lo = 1'b1;
      end
      if (h >= q && (!has_hi || h < $signed(ramp_tbl[hi].height))) begin
        hi     = i;
        has_hi = 1'b1;
      end
    end
    if (!has_lo) begin
      res = '{BELOW_RED, BELOW_GREEN, BELOW_BLUE, ST_BELOW};
    end else if (!has_hi) begin
      res = '{ABOVE_LEVEL, ABOVE_LEVEL, ABOVE_LEVEL, ST_ABOVE};
    end else if (ramp_tbl[lo].height == ramp_tbl[hi].height) begin
      res = '{ramp_tbl[lo].red, ramp_tbl[lo].green, ramp_tbl[lo].blue, ST_INTERP};
    end else begin
      num = q - $signed(ramp_tbl[lo].height);
      den = $signed(ramp_tbl[hi].height) - $signed(ramp_tbl[lo].height);
      res.out_red     = blend_channel(ramp_tbl[lo].red, ramp_tbl[hi].red, num, den);
      res.out_green   = blend_channel(ramp_tbl[lo].green, ramp_tbl[hi].green, num, den);
      res.out_blue    = blend_channel(ramp_tbl[lo].blue, ramp_tbl[hi].blue, num, den);
      res.ramp_status = ST_INTERP;
    end
    return res;
  endfunction

  // A request with every field random; callers then pin down what matters.
  function automatic crp_in_t random_request();
    crp_in_t req;
    req.operation    = 1'($urandom);
    req.point_slot   = 4'($urandom);
    req.point_height = 16'($urandom);
    req.point_red    = 8'($urandom);
    req.point_green  = 8'($urandom);
    req.point_blue   = 8'($urandom);
    req.query_height = 16'($urandom);
    return req;
  endfunction

  function automatic crp_in_t make_write(logic [3:0] slot, logic signed [15:0] height,
                                        logic [7:0] r, logic [7:0] g, logic [7:0] b);
    crp_in_t req;
    req              = random_request();
    req.operation    = OP_WRITE;
    req.point_slot   = slot;
    req.point_height = height;
    req.point_red    = r;
    req.point_green  = g;
    req.point_blue   = b;
    return req;
  endfunction

  function automatic crp_in_t make_lookup(logic signed [15:0] height);
    crp_in_t req;
    req              = random_request();
    req.operation    = OP_LOOKUP;
    req.query_height = height;
    return req;
  endfunction

  function automatic logic signed [15:0] pick_height(spread_t mode);
    case (mode)
      SPREAD_NARROW: return 16'($urandom_range(0, 80) - 40);
      SPREAD_MEDIUM: return 16'($urandom_range(0, 4000) - 2000);
      default:       return 16'($urandom);
    endcase
  endfunction

  // Query heights favor stored heights and their neighbors.
  function automatic logic signed [15:0] pick_query(spread_t mode);
    logic signed [15:0] stored;
    int                 span, sel;
    span   = (ramp_length < TABLE_SIZE) ? ramp_length : TABLE_SIZE;
    sel    = $urandom_range(0, 9);
    stored = ramp_tbl[$urandom_range(0, TABLE_SIZE - 1)].height;
    if (span > 0) begin
      stored = ramp_tbl[$urandom_range(0, span - 1)].height;
    end
    if (sel < 3) begin
      return stored;
    end else if (sel == 3) begin
      return $urandom_range(0, 1) ? stored + 16'sd1 : stored - 16'sd1;
    end else if (sel == 4) begin
      return 16'($urandom);
    end
    return pick_height(mode);
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_request(crp_in_t req);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    pending_colors.insert(pending_colors.size(), ramp_color(req));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every outstanding request has answered.
  task automatic wait_idle(int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_colors.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic set_ramp_length(int count);
    wait_idle(SETTLE_CYCLES);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 5'(count);
    ramp_length = count;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // An empty ramp puts every height below it.
  task automatic test_empty_ramp();
    set_ramp_length(0);
    send_request(make_lookup(-16'sd32768));
    send_request(make_lookup(16'sd32767));
    send_request(make_lookup(16'sd0));
  endtask

  // Four points with a duplicate height and channels that rise and fall.
  task automatic test_bracketing();
    send_request(make_write(4'd0, -16'sd1000, 8'd0, 8'd0, 8'd0));
    send_request(make_write(4'd1, 16'sd1000, 8'd0, 8'd255, 8'd255));
    send_request(make_write(4'd2, 16'sd1000, 8'd10, 8'd20, 8'd30));
    send_request(make_write(4'd3, 16'sd0, 8'd255, 8'd0, 8'd128));
    set_ramp_length(4);
    send_request(make_lookup(-16'sd32768));
    send_request(make_lookup(16'sd32767));
    send_request(make_lookup(-16'sd1000));
    send_request(make_lookup(16'sd1000));
    send_request(make_lookup(16'sd500));
    send_request(make_lookup(-16'sd1));
    send_request(make_lookup(16'sd999));
  endtask

  // A single point: below, exactly on it, and above.
  task automatic test_single_point();
    set_ramp_length(1);
    send_request(make_lookup(-16'sd1001));
    send_request(make_lookup(-16'sd1000));
    send_request(make_lookup(-16'sd999));
  endtask

  // Points at both ends of the height range give the widest span.
  task automatic test_full_scale();
    send_request(make_write(4'd0, -16'sd32768, 8'd255, 8'd255, 8'd255));
    send_request(make_write(4'd1, 16'sd32767, 8'd0, 8'd0, 8'd0));
    set_ramp_length(2);
    send_request(make_lookup(16'sd0));
    send_request(make_lookup(-16'sd32768));
    send_request(make_lookup(16'sd32767));
    send_request(make_lookup(-16'sd32767));
  endtask

  // Each phase rebuilds the whole table, then mixes lookups with rewrites.
  task automatic test_random_ramps(int phases, int per_phase);
    logic [3:0] order [TABLE_SIZE];
    logic [3:0] swap;
    spread_t    mode;
    int         count, j;
    for (int p = 0; p < phases; p++) begin
      mode = spread_t'(p % 3);
      case (p)
        0:       count = 31;
        1:       count = TABLE_SIZE;
        2:       count = 0;
        3:       count = 1;
        4:       count = 2;
        default: count = $urandom_range(3, 31);
      endcase
      set_ramp_length(count);
      idle_on = (p == phases - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (int i = 0; i < TABLE_SIZE; i++) begin
        order[i] = 4'(i);
      end
      for (int i = TABLE_SIZE - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        swap     = order[i];
        order[i] = order[j];
        order[j] = swap;
      end
      for (int i = 0; i < TABLE_SIZE; i++) begin
        send_request(make_write(order[i], pick_height(mode), 8'($urandom),
                                8'($urandom), 8'($urandom)));
      end
      for (int k = 0; k < per_phase; k++) begin
        if ($urandom_range(0, 9) < 3) begin
          send_request(make_write(4'($urandom), pick_height(mode), 8'($urandom),
                                  8'($urandom), 8'($urandom)));
        end else begin
          send_request(make_lookup(pick_query(mode)));
        end
      end
    end
  endtask

  // Result side back-pressure in bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each returned color with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_colors.size() == 0) begin
        err_count++;
        if (shown_count < SHOWN_LIMIT) begin
          shown_count++;
          $display("unexpected result rgb=(%0d,%0d,%0d) status=%0d", out_data.out_red,
                   out_data.out_green, out_data.out_blue, out_data.ramp_status);
        end
      end else begin
        expected_color = pending_colors.pop_front();
        if (out_data.out_red !== expected_color.out_red ||
            out_data.out_green !== expected_color.out_green ||
            out_data.out_blue !== expected_color.out_blue ||
            out_data.ramp_status !== expected_color.ramp_status) begin
          err_count++;
          if (shown_count < SHOWN_LIMIT) begin
            shown_count++;
            $display("mismatch: exp rgb=(%0d,%0d,%0d) st=%0d, got rgb=(%0d,%0d,%0d) st=%0d",
                     expected_color.out_red, expected_color.out_green,
                     expected_color.out_blue, expected_color.ramp_status,
                     out_data.out_red, out_data.out_green, out_data.out_blue,
                     out_data.ramp_status);
          end
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;
    test_empty_ramp();
    test_bracketing();
    test_single_point();
    test_full_scale();
    test_random_ramps(8, 112);
    wait_idle(DRAIN_CYCLES);
    if (err_count == 0) begin
      $display("tb_color_ramp_interpolation: clean");
    end else begin
      $display("tb_color_ramp_interpolation: errors");
    end
    $finish;
  end

endmodule
